### rtl/rgbyuv_pkg.sv
// Package for the RGB to YUV 4:2:2 pair-averaging core.
// Holds the beat payload types, BT.601 integer coefficients and queue sizing.
// No dependencies.
package rgbyuv_pkg;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
   } req_type;

   typedef struct packed {
      logic [7:0] luma;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
      logic       run_last;
   } rsp_type;

   // luma = ((66 R + 129 G + 25 B + 128) >> 8) + 16
   localparam logic [16:0] Y_COEF_R  = 17'd66;
   localparam logic [16:0] Y_COEF_G  = 17'd129;
   localparam logic [16:0] Y_COEF_B  = 17'd25;
   localparam logic [7:0]  Y_OFFSET  = 8'd16;

   // chroma = (sum + 128 + 32768) >> 8, sum never goes below -32768
   localparam logic [16:0] C_COEF_112 = 17'd112;
   localparam logic [16:0] U_COEF_R   = 17'd38;
   localparam logic [16:0] U_COEF_G   = 17'd74;
   localparam logic [16:0] V_COEF_G   = 17'd94;
   localparam logic [16:0] V_COEF_B   = 17'd18;
   localparam logic [16:0] ROUND_BIAS = 17'd128;
   localparam logic [16:0] C_BIAS     = 17'd32896;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

endpackage

### rtl/rgb_to_yuv422_pair_average_core.sv
// RGB to YUV 4:2:2 converter with horizontal chroma pair averaging.
// Depends on rgbyuv_pkg (payload types, coefficients, queue depth).
//
// Usage:
//   req channel: one RGB pixel per beat, raster order, row_end on the last
//   pixel of each row. rsp channel: one YUV pixel per beat.
//   The first pixel of a pair gives no beat; the second gives two beats
//   (held pixel, then this pixel) sharing the floor average of U and V.
//   A row_end pixel with no pixel held leaves alone with its own chroma.
//   run_last marks the last rsp beat caused by a req beat.
//   Timing: a pixel accepted into the input register is converted from it and
//   written into a 4-entry result queue once the queue has room; its beat(s) are
//   offered from the cycle after.
//   Throughput: one req beat per cycle sustained while rsp_ready stays high; the queue drains one rsp
//   beat per cycle, and a pair pushes two entries at once, so the input
//   register moves on only while the queue has two free entries.
//   Reset clears the input register, the pair state and the queue.
//   When the receiver stalls, the queue fills, then the input register
//   holds and req_ready drops; nothing is lost or repeated.
module rgb_to_yuv422_pair_average_core
   import rgbyuv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type           s1_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              pending_ff, pending_in;
   logic [7:0]        held_luma_ff, held_u_ff, held_v_ff;
   rsp_type           fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in, free_cnt;

   logic [16:0] r17, g17, b17, y_sum, u_sum, v_sum;
   logic [7:0]  y_pix, u_pix, v_pix, u_avg, v_avg;
   logic [8:0]  u_pair, v_pair;
   logic        pop, advance, hold_pix;
   logic [1:0]  push_cnt;
   rsp_type     entry0, entry1;

   // pixel conversion
   always_comb begin
      r17   = {9'd0, s1_ff.red};
      g17   = {9'd0, s1_ff.green};
      b17   = {9'd0, s1_ff.blue};
      y_sum = r17 * Y_COEF_R + g17 * Y_COEF_G + b17 * Y_COEF_B + ROUND_BIAS;
      u_sum = C_BIAS + b17 * C_COEF_112 - r17 * U_COEF_R - g17 * U_COEF_G;
      v_sum = C_BIAS + r17 * C_COEF_112 - g17 * V_COEF_G - b17 * V_COEF_B;
      y_pix = y_sum[15:8] + Y_OFFSET;
      u_pix = u_sum[15:8];
      v_pix = v_sum[15:8];
      u_pair = {1'b0, held_u_ff} + {1'b0, u_pix};
      v_pair = {1'b0, held_v_ff} + {1'b0, v_pix};
      u_avg = u_pair[8:1];
      v_avg = v_pair[8:1];
   end

   // queue control
   always_comb begin
      pop       = rsp_valid && rsp_ready;
      free_cnt  = CNT_W'(FIFO_DEPTH) - count_ff + {{(CNT_W-1){1'b0}}, pop};
      advance   = s1_valid_ff && (free_cnt >= CNT_W'(2));
      req_ready = !s1_valid_ff || advance;

      push_cnt = 2'd0;
      hold_pix = 1'b0;
      if (advance) begin
         if (pending_ff) begin
            push_cnt = 2'd2;
         end else if (s1_ff.row_end) begin
            push_cnt = 2'd1;
         end else begin
            hold_pix = 1'b1;
         end
      end

      if (pending_ff) begin
         entry0 = '{luma: held_luma_ff, chroma_u: u_avg, chroma_v: v_avg, run_last: 1'b0};
      end else begin
         entry0 = '{luma: y_pix, chroma_u: u_pix, chroma_v: v_pix, run_last: 1'b1};
      end
      entry1 = '{luma: y_pix, chroma_u: u_avg, chroma_v: v_avg, run_last: 1'b1};

      pending_in  = advance ? hold_pix : pending_ff;
      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push_cnt);
      count_in    = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);

      rsp_valid = (count_ff != '0);
      rsp_data  = fifo_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         pending_ff   <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         held_luma_ff <= '0;
         held_u_ff    <= '0;
         held_v_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         pending_ff  <= pending_in;
         rd_ptr_ff   <= rd_ptr_in;
         wr_ptr_ff   <= wr_ptr_in;
         count_ff    <= count_in;
         if (hold_pix) begin
            held_luma_ff <= y_pix;
            held_u_ff    <= u_pix;
            held_v_ff    <= v_pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_ff <= req_data;
      end
      if (push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= entry0;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= entry1;
      end
   end

endmodule
